[design/gha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants of the generational handle allocator: the
// command and status codes, the beat formats of both channels and the
// layout of one generation table entry.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Fixed field widths of the channel beats.
  localparam int HIDX_W = 10;
  localparam int GEN_W  = 16;

  // Defaults for the top level parameters.
  localparam int DEF_MAX_HANDLES    = 1024;
  localparam int DEF_MAX_GENERATION = 65534;

  // Command codes. The fourth code is unused and treated as a no-op.
  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_INVALID = 2'd2
  } status_e;

  // Input beat.
  typedef struct packed {
    cmd_e               command;
    logic [HIDX_W-1:0]  handle_index;
    logic [GEN_W-1:0]   handle_generation;
    logic               handle_is_null;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [HIDX_W-1:0]  out_index;
    logic [GEN_W-1:0]   out_generation;
    logic               handle_ok;
    status_e            status;
  } out_beat_t;

  // One word of the generation table: alive flag plus stored generation.
  typedef struct packed {
    logic               alive;
    logic [GEN_W-1:0]   generation;
  } tbl_entry_t;

endpackage

[design/gha_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port synchronous memory: one write port and one read port
// with registered read data. The read data holds while no read is issued.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/generational_handle_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Allocates, removes and checks handles made of an index and a generation.
// Freed indices are recycled oldest first through a free list memory; the
// per-index generation and alive flag live in a generation table memory.
//
//   channel | ports                        | beat
//   --------+------------------------------+-----------------------------
//   input   | in_valid, in_stall, in_data  | command and handle
//   result  | out_valid, out_stall, out_data | new handle, ok flag, status
//
// An allocate that reuses a freed index passes through an extra free list
// read step, because that read must finish before the table read of that
// index can be issued. One item is in flight at a time.
// Reset clears the counters and the control state; both memories start
// undefined; a table word read at an unused index is ignored by the check.
// A stalled result sits in the output register while the next item is
// accepted; that item waits at its final step until the register drains.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit
  import gha_pkg::*;
#(
  parameter int MAX_HANDLES    = DEF_MAX_HANDLES,
  parameter int MAX_GENERATION = DEF_MAX_GENERATION
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int IDX_W = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1;
  localparam int CNT_W = $clog2(MAX_HANDLES + 1);
  localparam int CMP_W = (CNT_W > HIDX_W) ? CNT_W : HIDX_W;
  localparam int OUT_W = (IDX_W > HIDX_W) ? IDX_W : HIDX_W;
  localparam int ENT_W = $bits(tbl_entry_t);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FIFO = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  // Free list pointer advance with wrap at the list depth.
  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(MAX_HANDLES - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  state_t            state_r, state_nxt;
  cmd_e              cmd_r;
  logic [HIDX_W-1:0] idx_r;
  logic [GEN_W-1:0]  gen_r;
  logic              null_r;
  logic              from_fifo_r, from_fifo_nxt;
  logic [IDX_W-1:0]  slot_r;

  logic [CNT_W-1:0]  used_count_r, used_count_nxt;
  logic [CNT_W-1:0]  fifo_count_r, fifo_count_nxt;
  logic [IDX_W-1:0]  fifo_head_r, fifo_head_nxt;
  logic [IDX_W-1:0]  fifo_tail_r, fifo_tail_nxt;

  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r, res;

  logic              in_fire, exec_fire;
  logic [CMP_W-1:0]  in_idx_ext, idx_ext, used_ext;

  logic              tbl_re, tbl_we;
  logic [IDX_W-1:0]  tbl_raddr, tbl_waddr;
  tbl_entry_t        tbl_wdata, tbl_rdata;
  logic [ENT_W-1:0]  tbl_rword;

  logic              fifo_re, fifo_we;
  logic [IDX_W-1:0]  fifo_rdata;

  logic              hvalid;
  logic [GEN_W-1:0]  gen_inc;
  logic [OUT_W-1:0]  slot_ext;

  // Handshake.
  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  assign in_idx_ext = CMP_W'(in_data.handle_index);
  assign idx_ext    = CMP_W'(idx_r);
  assign used_ext   = CMP_W'(used_count_r);

  // Memory read requests: the free list head on a recycling allocate, the
  // table at the handle index on remove or check, or at the popped index.
  assign fifo_re   = in_fire && (in_data.command == CMD_ALLOC) && (fifo_count_r != '0);
  assign tbl_re    = (in_fire && ((in_data.command == CMD_REMOVE) ||
                                  (in_data.command == CMD_CHECK))) ||
                     (state_r == S_FIFO);
  assign tbl_raddr = (state_r == S_FIFO) ? fifo_rdata : in_idx_ext[IDX_W-1:0];

  gha_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_HANDLES)
  ) u_gen_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_en   (tbl_re),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rword)
  );

  assign tbl_rdata = tbl_entry_t'(tbl_rword);

  gha_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_HANDLES)
  ) u_free_list (
    .clk     (clk),
    .wr_en   (fifo_we),
    .wr_addr (fifo_tail_r),
    .wr_data (idx_ext[IDX_W-1:0]),
    .rd_en   (fifo_re),
    .rd_addr (fifo_head_r),
    .rd_data (fifo_rdata)
  );

  // Handle validity from the table word read for this item.
  assign hvalid  = !null_r && (idx_ext < used_ext) && tbl_rdata.alive &&
                   (tbl_rdata.generation == gen_r);
  assign gen_inc = tbl_rdata.generation + 1'b1;

  // Final step: form the result and the table and list updates.
  always_comb begin
    res              = '0;
    res.status       = STAT_DONE;
    tbl_we           = 1'b0;
    tbl_waddr        = idx_ext[IDX_W-1:0];
    tbl_wdata        = '0;
    fifo_we          = 1'b0;
    used_count_nxt   = used_count_r;
    fifo_count_nxt   = fifo_count_r;
    fifo_head_nxt    = fifo_head_r;
    fifo_tail_nxt    = fifo_tail_r;
    slot_ext         = '0;
    case (cmd_r)
      CMD_ALLOC: begin
        if (from_fifo_r) begin
          slot_ext             = OUT_W'(slot_r);
          res.out_index        = slot_ext[HIDX_W-1:0];
          res.out_generation   = tbl_rdata.generation;
          tbl_waddr            = slot_r;
          tbl_wdata.alive      = 1'b1;
          tbl_wdata.generation = tbl_rdata.generation;
          tbl_we               = exec_fire;
          if (exec_fire) begin
            fifo_head_nxt  = wrap_next(fifo_head_r);
            fifo_count_nxt = fifo_count_r - 1'b1;
          end
        end else if (used_count_r < CNT_W'(MAX_HANDLES)) begin
          slot_ext             = OUT_W'(used_count_r);
          res.out_index        = slot_ext[HIDX_W-1:0];
          tbl_waddr            = used_count_r[IDX_W-1:0];
          tbl_wdata.alive      = 1'b1;
          tbl_wdata.generation = '0;
          tbl_we               = exec_fire;
          if (exec_fire) begin
            used_count_nxt = used_count_r + 1'b1;
          end
        end else begin
          res.status = STAT_FULL;
        end
      end
      CMD_REMOVE: begin
        if (hvalid) begin
          res.handle_ok        = 1'b1;
          tbl_wdata.alive      = 1'b0;
          tbl_wdata.generation = gen_inc;
          tbl_we               = exec_fire;
          // Requeue unless the generation has run past its limit or the list is full.
          if (exec_fire && ({1'b0, gen_inc} <= (GEN_W + 1)'(MAX_GENERATION)) &&
              (fifo_count_r < CNT_W'(MAX_HANDLES))) begin
            fifo_we        = 1'b1;
            fifo_tail_nxt  = wrap_next(fifo_tail_r);
            fifo_count_nxt = fifo_count_r + 1'b1;
          end
        end else begin
          res.status = STAT_INVALID;
        end
      end
      CMD_CHECK: begin
        res.handle_ok = hvalid;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    from_fifo_nxt = from_fifo_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          from_fifo_nxt = fifo_re;
          state_nxt     = fifo_re ? S_FIFO : S_EXEC;
        end
      end
      S_FIFO: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      from_fifo_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      used_count_r <= '0;
      fifo_count_r <= '0;
      fifo_head_r  <= '0;
      fifo_tail_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      from_fifo_r  <= from_fifo_nxt;
      out_valid_r  <= out_valid_nxt;
      used_count_r <= used_count_nxt;
      fifo_count_r <= fifo_count_nxt;
      fifo_head_r  <= fifo_head_nxt;
      fifo_tail_r  <= fifo_tail_nxt;
    end
  end

  // Item payload, popped index and result data.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_data.command;
      idx_r  <= in_data.handle_index;
      gen_r  <= in_data.handle_generation;
      null_r <= in_data.handle_is_null;
    end
    if (state_r == S_FIFO) begin
      slot_r <= fifo_rdata;
    end
    if (exec_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // The free list only ever holds indices that were handed out.
  a_fifo_le_used : assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count_r <= used_count_r)
    else $error("free list holds more entries than indices handed out");

  // The free list read step is entered only for an allocate with queued indices.
  a_fifo_step : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIFO) |-> ((cmd_r == CMD_ALLOC) && (fifo_count_r != '0)))
    else $error("free list step entered without a queued index");

  // A result that accepts a handle never reports a failure.
  a_ok_status : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.handle_ok) |-> (out_data_r.status == STAT_DONE))
    else $error("valid handle reported with a failure status");

  // A fresh allocate advances the used count by exactly one.
  a_used_inc : assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && (cmd_r == CMD_ALLOC) && !from_fifo_r &&
     (used_count_r < CNT_W'(MAX_HANDLES)))
    |=> (used_count_r == $past(used_count_r) + 1'b1))
    else $error("fresh allocate did not advance the used count");
`endif

endmodule
